>>> rtl/core/tpr_pkg.sv
// shared widths, register indexes and format codes for the texture pixel repacker
package tpr_pkg;

    // channel payload widths
    localparam int COMP_W     = 8;
    localparam int PACKED_W   = 32;
    localparam int ADDR_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HAS_ALPHA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT    = 3'd3;

    // output format codes
    typedef logic [1:0] fmt_t;
    localparam fmt_t FMT_RGBA8888 = 2'd0;
    localparam fmt_t FMT_RGB565   = 2'd1;
    localparam fmt_t FMT_RGBA4444 = 2'd2;
    localparam fmt_t FMT_RGB5A1   = 2'd3;

    typedef logic [COMP_W-1:0] comp_t;

    localparam comp_t ALPHA_OPAQUE = 8'hFF;

endpackage

>>> rtl/core/tpr_if.sv
// valid/ready channel interfaces for pixels, texels and configuration writes
interface tpr_pixel_if
    import tpr_pkg::*;
();
    logic  valid;
    logic  ready;
    comp_t red;
    comp_t green;
    comp_t blue;
    comp_t alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface tpr_texel_if
    import tpr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PACKED_W-1:0] packed_pixel;
    logic [ADDR_W-1:0]   texel_address;
    logic                image_done;

    modport source (output valid, output packed_pixel, output texel_address,
                    output image_done, input ready);
    modport sink   (input valid, input packed_pixel, input texel_address,
                    input image_done, output ready);
endinterface

interface tpr_cfg_if
    import tpr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/texture_pixel_repacker_top.sv
// texture pixel repacker: premultiply (with source alpha), pack and address one raster pixel per cycle unless stalled
// a result passes two register stages, input then result, before it is valid on the output
// throughput: one pixel per cycle while the output is not stalled, set by the input and result register stages
// stalls on the output hold both stages; the input takes a pixel whenever stage one frees
// reset: counters at column 0 row 0, width 1, height 1, no alpha, rgba8888 format
// configuration writes are always ready and take effect at once
module texture_pixel_repacker_top
    import tpr_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = 12
)(
    input  logic        clk,
    input  logic        rst_n,
    tpr_pixel_if.sink   pix_in,
    tpr_texel_if.source tex_out,
    tpr_cfg_if.sink     cfg
);

    localparam int CNT_W = MAX_SIDE_LOG2;
    localparam int SW    = MAX_SIDE_LOG2 + 1;
    localparam int CMP_W = CFG_DATA_W + 1;
    localparam int KW    = $clog2(MAX_SIDE_LOG2 + 1);
    localparam int AW    = 2 * MAX_SIDE_LOG2 + ADDR_W;
    localparam int PW    = 2 * COMP_W + 1;
    localparam logic [CMP_W-1:0] SIDE_TOP = CMP_W'(1) << MAX_SIDE_LOG2;

    // configuration state
    logic [SW-1:0] width_reg;
    logic [SW-1:0] height_reg;
    logic [KW-1:0] pad_log2_reg;
    logic          has_alpha_reg;
    fmt_t          format_reg;

    // raster counters
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;

    // stage one: input register
    logic              s1_valid_reg;
    comp_t             s1_red_reg, s1_green_reg, s1_blue_reg, s1_alpha_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_done_reg;

    // stage two: result register
    logic                out_valid_reg;
    logic [PACKED_W-1:0] out_packed_reg, out_packed_next;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_done_reg;

    logic s2_ready;
    logic in_xfer;
    logic cfg_xfer;
    logic size_write;

    logic [SW-1:0] wr_side;
    logic [KW-1:0] wr_log2;

    logic          last_col;
    logic          last_row;
    logic [AW-1:0] addr_wide;

    comp_t r_pm, g_pm, b_pm, a_eff;
    logic [2*COMP_W:0] r_prod, g_prod, b_prod;

    // side clamp: zero counts as one, anything above the top counts as the top
    function automatic logic [SW-1:0] clamp_side(input logic [CFG_DATA_W-1:0] s);
        logic [CMP_W-1:0] s_ext;
        logic [CMP_W-1:0] c;
        s_ext = {1'b0, s};
        if (s_ext == '0)
            c = CMP_W'(1);
        else if (s_ext > SIDE_TOP)
            c = SIDE_TOP;
        else
            c = s_ext;
        return SW'(c);
    endfunction

    // handshakes
    assign s2_ready      = !out_valid_reg || tex_out.ready;
    assign pix_in.ready  = !s1_valid_reg || s2_ready;
    assign in_xfer       = pix_in.valid && pix_in.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_xfer      = cfg.valid;
    assign size_write    = cfg_xfer &&
                           (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT);

    // clamped side and padded log2 of the written width
    always_comb
    begin
        wr_side = clamp_side(cfg.data);
        wr_log2 = '0;
        for (int i = MAX_SIDE_LOG2; i >= 0; i--)
        begin
            if ((SW'(1) << i) >= wr_side)
                wr_log2 = KW'(i);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SW'(1);
            height_reg    <= SW'(1);
            pad_log2_reg  <= '0;
            has_alpha_reg <= 1'b0;
            format_reg    <= FMT_RGBA8888;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    width_reg    <= wr_side;
                    pad_log2_reg <= wr_log2;
                end
                REG_IMAGE_HEIGHT:     height_reg    <= wr_side;
                REG_SOURCE_HAS_ALPHA: has_alpha_reg <= cfg.data[0];
                REG_OUTPUT_FORMAT:    format_reg    <= fmt_t'(cfg.data[1:0]);
                default:              ;
            endcase
        end
    end

    // raster position, address and end of image
    always_comb
    begin
        last_col  = (SW'(col_reg) + SW'(1)) >= width_reg;
        last_row  = (SW'(row_reg) + SW'(1)) >= height_reg;
        addr_wide = (AW'(row_reg) << pad_log2_reg) | AW'(col_reg);
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage one valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_in.ready)
            s1_valid_reg <= pix_in.valid;
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_red_reg   <= pix_in.red;
            s1_green_reg <= pix_in.green;
            s1_blue_reg  <= pix_in.blue;
            s1_alpha_reg <= pix_in.alpha;
            s1_addr_reg  <= addr_wide[ADDR_W-1:0];
            s1_done_reg  <= last_col && last_row;
        end
    end

    // premultiply when the source has alpha, then pack
    always_comb
    begin
        r_prod = PW'(s1_red_reg)   * PW'(s1_alpha_reg) + PW'(s1_red_reg);
        g_prod = PW'(s1_green_reg) * PW'(s1_alpha_reg) + PW'(s1_green_reg);
        b_prod = PW'(s1_blue_reg)  * PW'(s1_alpha_reg) + PW'(s1_blue_reg);
        if (has_alpha_reg)
        begin
            r_pm  = r_prod[2*COMP_W-1:COMP_W];
            g_pm  = g_prod[2*COMP_W-1:COMP_W];
            b_pm  = b_prod[2*COMP_W-1:COMP_W];
            a_eff = s1_alpha_reg;
        end
        else
        begin
            r_pm  = s1_red_reg;
            g_pm  = s1_green_reg;
            b_pm  = s1_blue_reg;
            a_eff = ALPHA_OPAQUE;
        end
        unique case (format_reg)
            FMT_RGBA8888: out_packed_next = {a_eff, b_pm, g_pm, r_pm};
            FMT_RGB565:   out_packed_next = {16'h0, r_pm[7:3], g_pm[7:2], b_pm[7:3]};
            FMT_RGBA4444: out_packed_next = {16'h0, r_pm[7:4], g_pm[7:4], b_pm[7:4],
                                             a_eff[7:4]};
            FMT_RGB5A1:   out_packed_next = {16'h0, r_pm[7:3], g_pm[7:3], b_pm[7:3],
                                             a_eff[7]};
            default:      out_packed_next = '0;
        endcase
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_packed_reg <= out_packed_next;
            out_addr_reg   <= s1_addr_reg;
            out_done_reg   <= s1_done_reg;
        end
    end

    // output channel
    assign tex_out.valid         = out_valid_reg;
    assign tex_out.packed_pixel  = out_packed_reg;
    assign tex_out.texel_address = out_addr_reg;
    assign tex_out.image_done    = out_done_reg;

endmodule
